// ===== rtl/core/sha1_pkg.sv =====
`default_nettype none

package sha1_pkg;

    localparam int WORD_W     = 32;
    localparam int TDATA_W    = 40;
    localparam int CNT_W      = 3;
    localparam int PTR_W      = 4;
    localparam int ROUND_W    = 7;
    localparam int LEN_W      = 64;
    localparam int NUM_WORDS  = 16;
    localparam int NUM_CHAIN  = 5;

    localparam logic [PTR_W-1:0]   LAST_PTR    = 4'd15;
    localparam logic [PTR_W-1:0]   LEN_HI_PTR  = 4'd14;
    localparam logic [ROUND_W-1:0] LAST_ROUND  = 7'd79;
    localparam logic [CNT_W-1:0]   FULL_BYTES  = 3'd4;
    localparam logic [CNT_W-1:0]   LAST_INDEX  = 3'd4;

    // Round constants
    localparam logic [WORD_W-1:0] K_0 = 32'h5a827999;
    localparam logic [WORD_W-1:0] K_1 = 32'h6ed9eba1;
    localparam logic [WORD_W-1:0] K_2 = 32'h8f1bbcdc;
    localparam logic [WORD_W-1:0] K_3 = 32'hca62c1d6;

    // Padding word holding only the end-of-message marker byte
    localparam logic [WORD_W-1:0] MARK_WORD = 32'h80000000;

    // Initial chaining values
    localparam logic [WORD_W-1:0] H_INIT [NUM_CHAIN] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PAD  = 4'b0010,
        S_COMP = 4'b0100,
        S_ADD  = 4'b1000
    } t_state;

    // Source of the word shifted into the block window
    typedef enum logic [2:0] {
        SEL_DATA,
        SEL_DATA_MARK,
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN_HI,
        SEL_LEN_LO,
        SEL_SCHED
    } t_sel;

    // Where to go after a compression
    typedef enum logic [1:0] {
        RET_IDLE,
        RET_PAD,
        RET_DONE
    } t_ret;

    typedef struct packed {
        logic               shift_en;
        t_sel               sel;
        logic               len_add;
        logic               load_vars;
        logic               round_en;
        logic [ROUND_W-1:0] round;
        logic               add_chain;
        logic               finish;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_stat;

    // Bytes taken from one beat: four unless a short count on the last beat
    function automatic logic [CNT_W-1:0] eff_bytes(input logic [CNT_W-1:0] vb,
                                                   input logic            last);
        logic [CNT_W-1:0] n;
        n = vb;
        if (!last || vb > FULL_BYTES) begin
            n = FULL_BYTES;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sha1_ctrl.sv =====
`default_nettype none

module sha1_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_last,
    input  wire logic [2:0]           i_in_vb,
    output logic                      o_in_ready,
    input  wire sha1_pkg::t_stat      i_stat,
    output sha1_pkg::t_cmd            o_cmd
);

    sha1_pkg::t_state r_state, n_state;
    sha1_pkg::t_ret   r_ret, n_ret;
    logic [sha1_pkg::PTR_W-1:0]   r_ptr, n_ptr;
    logic [sha1_pkg::ROUND_W-1:0] r_round, n_round;
    logic r_mark, n_mark;
    logic r_len_hi, n_len_hi;

    logic accept;
    logic partial;

    assign o_in_ready = (r_state == sha1_pkg::S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign partial    = i_in_last &&
                        (sha1_pkg::eff_bytes(i_in_vb, i_in_last) != sha1_pkg::FULL_BYTES);

    // Next state and datapath commands
    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_ptr    = r_ptr;
        n_round  = r_round;
        n_mark   = r_mark;
        n_len_hi = r_len_hi;

        o_cmd.shift_en  = 1'b0;
        o_cmd.sel       = sha1_pkg::SEL_ZERO;
        o_cmd.len_add   = 1'b0;
        o_cmd.load_vars = 1'b0;
        o_cmd.round_en  = 1'b0;
        o_cmd.round     = r_round;
        o_cmd.add_chain = 1'b0;
        o_cmd.finish    = 1'b0;

        unique case (r_state)
            sha1_pkg::S_IDLE: begin
                if (accept) begin
                    o_cmd.shift_en = 1'b1;
                    o_cmd.len_add  = 1'b1;
                    o_cmd.sel      = partial ? sha1_pkg::SEL_DATA_MARK : sha1_pkg::SEL_DATA;
                    n_ptr          = r_ptr + 1'b1;
                    n_mark         = partial;
                    n_len_hi       = 1'b0;
                    if (r_ptr == sha1_pkg::LAST_PTR) begin
                        o_cmd.load_vars = 1'b1;
                        n_round         = '0;
                        n_state         = sha1_pkg::S_COMP;
                        n_ret           = i_in_last ? sha1_pkg::RET_PAD : sha1_pkg::RET_IDLE;
                    end else if (i_in_last) begin
                        n_state = sha1_pkg::S_PAD;
                    end
                end
            end
            sha1_pkg::S_PAD: begin
                // One padding word per cycle
                o_cmd.shift_en = 1'b1;
                n_ptr          = r_ptr + 1'b1;
                if (!r_mark) begin
                    o_cmd.sel = sha1_pkg::SEL_MARK;
                    n_mark    = 1'b1;
                    if (r_ptr == sha1_pkg::LAST_PTR) begin
                        o_cmd.load_vars = 1'b1;
                        n_round         = '0;
                        n_state         = sha1_pkg::S_COMP;
                        n_ret           = sha1_pkg::RET_PAD;
                    end
                end else if (r_ptr == sha1_pkg::LEN_HI_PTR) begin
                    o_cmd.sel = sha1_pkg::SEL_LEN_HI;
                    n_len_hi  = 1'b1;
                end else if (r_ptr == sha1_pkg::LAST_PTR) begin
                    o_cmd.sel       = r_len_hi ? sha1_pkg::SEL_LEN_LO : sha1_pkg::SEL_ZERO;
                    o_cmd.load_vars = 1'b1;
                    n_round         = '0;
                    n_state         = sha1_pkg::S_COMP;
                    n_ret           = r_len_hi ? sha1_pkg::RET_DONE : sha1_pkg::RET_PAD;
                end else begin
                    o_cmd.sel = sha1_pkg::SEL_ZERO;
                end
            end
            sha1_pkg::S_COMP: begin
                // One round per cycle, schedule word rolls through the window
                o_cmd.round_en = 1'b1;
                o_cmd.shift_en = 1'b1;
                o_cmd.sel      = sha1_pkg::SEL_SCHED;
                n_round        = r_round + 1'b1;
                if (r_round == sha1_pkg::LAST_ROUND) begin
                    n_round = '0;
                    n_state = sha1_pkg::S_ADD;
                end
            end
            sha1_pkg::S_ADD: begin
                if (r_ret == sha1_pkg::RET_DONE) begin
                    // Hold until the previous digest has left
                    if (!i_stat.out_busy) begin
                        o_cmd.finish = 1'b1;
                        n_mark       = 1'b0;
                        n_len_hi     = 1'b0;
                        n_state      = sha1_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.add_chain = 1'b1;
                    n_state = (r_ret == sha1_pkg::RET_PAD) ? sha1_pkg::S_PAD
                                                           : sha1_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sha1_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sha1_pkg::S_IDLE;
            r_ret    <= sha1_pkg::RET_IDLE;
            r_ptr    <= '0;
            r_round  <= '0;
            r_mark   <= 1'b0;
            r_len_hi <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_ptr    <= n_ptr;
            r_round  <= n_round;
            r_mark   <= n_mark;
            r_len_hi <= n_len_hi;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sha1_dpath.sv =====
`default_nettype none

module sha1_dpath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire sha1_pkg::t_cmd               i_cmd,
    output sha1_pkg::t_stat                   o_stat,
    input  wire logic [sha1_pkg::WORD_W-1:0]  i_data,
    input  wire logic [2:0]                   i_vb,
    input  wire logic                         i_last,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [sha1_pkg::WORD_W-1:0]       o_out_word,
    output logic [2:0]                        o_out_index,
    output logic                              o_out_last
);

    localparam int W = sha1_pkg::WORD_W;

    logic [W-1:0] r_w [sha1_pkg::NUM_WORDS];
    logic [W-1:0] r_h [sha1_pkg::NUM_CHAIN];
    logic [W-1:0] r_dig [sha1_pkg::NUM_CHAIN];
    logic [W-1:0] r_a, r_b, r_c, r_d, r_e;
    logic [sha1_pkg::LEN_W-1:0] r_len;
    logic         r_out_valid;
    logic [2:0]   r_out_idx;

    logic [2:0]   eff;
    logic [W-1:0] marked_word;
    logic [W-1:0] sched_x;
    logic [W-1:0] w_round;
    logic [W-1:0] f_val, k_val, t_val;
    logic [W-1:0] shift_word;

    assign eff = sha1_pkg::eff_bytes(i_vb, i_last);

    // Keep leading bytes of a short final beat and append the marker byte
    always_comb begin
        case (eff)
            3'd0:    marked_word = sha1_pkg::MARK_WORD;
            3'd1:    marked_word = {i_data[31:24], 24'h800000};
            3'd2:    marked_word = {i_data[31:16], 16'h8000};
            3'd3:    marked_word = {i_data[31:8], 8'h80};
            default: marked_word = i_data;
        endcase
    end

    // Message schedule word for this round
    assign sched_x = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_round = (i_cmd.round < 7'd16) ? r_w[0] : {sched_x[W-2:0], sched_x[W-1]};

    // Round function and constant
    always_comb begin
        if (i_cmd.round < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = sha1_pkg::K_0;
        end else if (i_cmd.round < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = sha1_pkg::K_1;
        end else if (i_cmd.round < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = sha1_pkg::K_2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = sha1_pkg::K_3;
        end
    end

    assign t_val = {r_a[W-6:0], r_a[W-1:W-5]} + f_val + r_e + w_round + k_val;

    // Word entering the block window
    always_comb begin
        case (i_cmd.sel)
            sha1_pkg::SEL_DATA:      shift_word = i_data;
            sha1_pkg::SEL_DATA_MARK: shift_word = marked_word;
            sha1_pkg::SEL_MARK:      shift_word = sha1_pkg::MARK_WORD;
            sha1_pkg::SEL_LEN_HI:    shift_word = r_len[sha1_pkg::LEN_W-1:W];
            sha1_pkg::SEL_LEN_LO:    shift_word = r_len[W-1:0];
            sha1_pkg::SEL_SCHED:     shift_word = w_round;
            default:                 shift_word = '0;
        endcase
    end

    // Block window: words enter at the top and move down
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_en) begin
            for (int i = 0; i < sha1_pkg::NUM_WORDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[sha1_pkg::NUM_WORDS-1] <= shift_word;
        end
    end

    // Working variables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
            r_b <= '0;
            r_c <= '0;
            r_d <= '0;
            r_e <= '0;
        end else if (i_cmd.load_vars) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_cmd.round_en) begin
            r_a <= t_val;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[W-1:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    // Chaining words and message length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sha1_pkg::NUM_CHAIN; i++) begin
                r_h[i] <= sha1_pkg::H_INIT[i];
            end
            r_len <= '0;
        end else begin
            if (i_cmd.finish) begin
                for (int i = 0; i < sha1_pkg::NUM_CHAIN; i++) begin
                    r_h[i] <= sha1_pkg::H_INIT[i];
                end
            end else if (i_cmd.add_chain) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
            if (i_cmd.finish) begin
                r_len <= '0;
            end else if (i_cmd.len_add) begin
                r_len <= r_len + {{(sha1_pkg::LEN_W-6){1'b0}}, eff, 3'b000};
            end
        end
    end

    // Digest output buffer: shift one word out per beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_dig[0] <= r_h[0] + r_a;
            r_dig[1] <= r_h[1] + r_b;
            r_dig[2] <= r_h[2] + r_c;
            r_dig[3] <= r_h[3] + r_d;
            r_dig[4] <= r_h[4] + r_e;
        end else if (r_out_valid && i_out_ready) begin
            for (int i = 0; i < sha1_pkg::NUM_CHAIN - 1; i++) begin
                r_dig[i] <= r_dig[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_idx   <= '0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
            r_out_idx   <= '0;
        end else if (r_out_valid && i_out_ready) begin
            r_out_idx <= r_out_idx + 1'b1;
            if (r_out_idx == sha1_pkg::LAST_INDEX) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_busy = r_out_valid;
    assign o_out_valid     = r_out_valid;
    assign o_out_word      = r_dig[0];
    assign o_out_index     = r_out_idx;
    assign o_out_last      = (r_out_idx == sha1_pkg::LAST_INDEX);

endmodule

`default_nettype wire

// ===== rtl/core/sha1_stream_hasher.sv =====
`default_nettype none

// SHA-1 hasher for a stream of big-endian 32-bit message words (first byte in
// bits 31:24). Each beat carries four bytes; only the beat marked tlast may
// carry fewer (0 to 3, given in tdata[34:32]), and a tlast beat with zero bytes
// just closes the message. Words are taken one per cycle until sixteen fill a
// block, then input stalls while the single round unit runs the 80 rounds,
// one round per cycle, and then folds the result into the chaining words.
// After the tlast beat the block writes padding and length words one per
// cycle, runs one or two more compressions, and presents the digest as five
// output beats, most significant word first, index in tdata[34:32] and tlast
// on the fifth. A new message may start while the digest is still being
// drained.
module sha1_stream_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // data_word[31:0], valid_bytes[34:32], zero
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // digest_word[31:0], word_index[34:32], zero
    output logic             m_axis_tlast
);

    sha1_pkg::t_cmd  cmd;
    sha1_pkg::t_stat stat;

    logic [sha1_pkg::WORD_W-1:0] out_word;
    logic [2:0]                  out_index;

    sha1_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .i_in_vb    (s_axis_tdata[34:32]),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sha1_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_data      (s_axis_tdata[31:0]),
        .i_vb        (s_axis_tdata[34:32]),
        .i_last      (s_axis_tlast),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_word  (out_word),
        .o_out_index (out_index),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b00000, out_index, out_word};

endmodule

`default_nettype wire

// ===== rtl/core/sha1_chk.sv =====
`default_nettype none

module sha1_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [39:0] s_axis_tdata,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // Digest words follow one another with rising index
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
            (m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1))
        else $error("digest word index did not advance by one");

    // A digest always starts at word zero
    a_digest_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> (m_axis_tdata[34:32] == 3'd0 && !m_axis_tlast))
        else $error("digest did not start at word zero");

    // Closing a message makes the input wait for padding
    a_last_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input taken right after the last beat of a message");

    // Stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output beat changed while stalled");

endmodule

bind sha1_stream_hasher sha1_chk u_sha1_chk (.*);

`default_nettype wire
